>>> rtl/mcqw_pkg.sv
// Package for the motor command queue watchdog: payload structs, queue entry
// layout, command codes, controller states and the control/status bundles.
// No dependencies.
package mcqw_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

    localparam logic [7:0] CODE_PING   = 8'd2;
    localparam logic [7:0] CODE_STOP   = 8'd3;
    localparam logic [7:0] CODE_SPEEDS = 8'd4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POLL = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  command_code;
        logic [7:0]  speed_left;
        logic [7:0]  speed_right;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] motor_left;
        logic [7:0] motor_right;
        logic       motor_write;
        logic       moving;
        logic       timed_out;
        logic       command_taken;
        logic       push_dropped;
    } t_out_item;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] left;
        logic [7:0] right;
    } t_q_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/mcqw_ctrl.sv
// Controller state machine of the motor command queue watchdog.
// Depends on mcqw_pkg for the state enum and the command/status structs.
module mcqw_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  mcqw_pkg::t_dp_status   i_status,
    output logic                   o_in_stall,
    output mcqw_pkg::t_ctrl_cmd    o_cmd
);

    mcqw_pkg::t_state r_state;
    mcqw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcqw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        case (r_state)
            mcqw_pkg::ST_IDLE: begin
                o_in_stall = !i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = mcqw_pkg::ST_READ;
                end
            end
            // The queue head is read into a register during this cycle.
            mcqw_pkg::ST_READ: begin
                n_state = mcqw_pkg::ST_EXEC;
            end
            mcqw_pkg::ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = mcqw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcqw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/mcqw_dp.sv
// Datapath of the motor command queue watchdog: command queue memory,
// motor state, watchdog compare, timeout register and output register.
// Depends on mcqw_pkg for payload structs, codes and command/status structs.
module mcqw_dp #(
    parameter int QUEUE_DEPTH = mcqw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata,
    input  mcqw_pkg::t_in_item     i_in_item,
    input  mcqw_pkg::t_ctrl_cmd    i_cmd,
    input  logic                   i_out_stall,
    output mcqw_pkg::t_dp_status   o_status,
    output logic                   o_out_valid,
    output mcqw_pkg::t_out_item    o_out_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mcqw_pkg::t_q_entry  r_mem [QUEUE_DEPTH];
    mcqw_pkg::t_q_entry  r_rd_data;
    mcqw_pkg::t_in_item  r_item;
    mcqw_pkg::t_out_item r_out_item;
    mcqw_pkg::t_out_item n_out_item;

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_left, n_left;
    logic [7:0]       r_right, n_right;
    logic             r_moving, n_moving;
    logic [31:0]      r_last_time, n_last_time;
    logic [15:0]      r_timeout;
    logic             r_out_valid, n_out_valid;
    logic             mem_we;
    logic [31:0]      elapsed;

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;
    assign elapsed           = r_item.now_ms - r_last_time;

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_left      = r_left;
        n_right     = r_right;
        n_moving    = r_moving;
        n_last_time = r_last_time;
        mem_we      = 1'b0;
        n_out_item  = '0;

        if (r_item.op == mcqw_pkg::OP_PUSH) begin
            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                n_out_item.push_dropped = 1'b1;
            end else begin
                mem_we   = 1'b1;
                n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (r_count != '0) begin
                case (r_rd_data.code)
                    mcqw_pkg::CODE_STOP: begin
                        n_left                   = '0;
                        n_right                  = '0;
                        n_moving                 = 1'b0;
                        n_out_item.motor_write   = 1'b1;
                        n_out_item.command_taken = 1'b1;
                    end
                    mcqw_pkg::CODE_SPEEDS: begin
                        n_left                   = r_rd_data.left;
                        n_right                  = r_rd_data.right;
                        n_moving                 = (r_rd_data.left != '0) ||
                                                   (r_rd_data.right != '0);
                        n_out_item.motor_write   = 1'b1;
                        n_out_item.command_taken = 1'b1;
                    end
                    mcqw_pkg::CODE_PING: begin
                        n_out_item.command_taken = 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                n_count  = r_count - 1'b1;
            end
            if (n_out_item.command_taken) begin
                n_last_time = r_item.now_ms;
            end else if (r_moving && (elapsed > {16'd0, r_timeout})) begin
                n_left                 = '0;
                n_right                = '0;
                n_moving               = 1'b0;
                n_out_item.motor_write = 1'b1;
                n_out_item.timed_out   = 1'b1;
            end
        end

        n_out_item.motor_left  = n_left;
        n_out_item.motor_right = n_right;
        n_out_item.moving      = n_moving;

        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    // Queue memory: one write port, one registered read port at the head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && mem_we) begin
            r_mem[r_wr_ptr] <= '{code:  r_item.command_code,
                                 left:  r_item.speed_left,
                                 right: r_item.speed_right};
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.commit) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_moving    <= 1'b0;
            r_last_time <= '0;
            r_timeout   <= mcqw_pkg::TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_wr_ptr    <= n_wr_ptr;
                r_rd_ptr    <= n_rd_ptr;
                r_count     <= n_count;
                r_left      <= n_left;
                r_right     <= n_right;
                r_moving    <= n_moving;
                r_last_time <= n_last_time;
            end
        end
    end

endmodule

>>> rtl/motor_command_queue_watchdog.sv
// Top level of the motor command queue watchdog.
// Depends on mcqw_pkg, mcqw_ctrl and mcqw_dp.
//
// Usage: the input channel (i_in_valid / o_in_stall / i_in_item) carries one
// transaction per item. A push (op 0) stores a command code and two speed
// bytes in the command queue; when the queue is full the push is discarded
// and its result reports push_dropped. A poll (op 1) carries the current
// millisecond time, takes at most one queued command and applies it: stop
// zeroes both motors, speeds loads both motors, ping only refreshes the
// contact time. Without a recognized command, moving motors are stopped once
// the time since the last contact (modulo 2^32) exceeds timeout_ms.
// Every item produces exactly one result transaction on the output channel
// (o_out_valid / i_out_stall / o_out_item).
// The result is registered: an item passes through accept, a registered read
// of the queue head from the queue memory, then execution, and a new item
// is accepted only once the last one has left execution. The output register
// holds a finished result while the receiver stalls; the next item is still
// accepted and waits in execution until the output register frees up. The
// user must write the timeout register (i_cfg_we / i_cfg_wdata) only while
// the block is idle; the block itself does not enforce this.
// Reset (synchronous, active low) empties the queue, zeroes both motors,
// clears the contact time, loads a timeout of 3000 ms and drops any pending
// result. The input channel stalls while reset is asserted.
module motor_command_queue_watchdog #(
    parameter int QUEUE_DEPTH = mcqw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mcqw_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mcqw_pkg::t_out_item  o_out_item
);

    // Controller to datapath commands and the datapath's status back.
    mcqw_pkg::t_ctrl_cmd  cmd;
    mcqw_pkg::t_dp_status status;

    // The controller sequences each item through capture, head read and
    // execution; it never touches payload.
    mcqw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the queue, motor state, watchdog and the output
    // register that separates the two channels.
    mcqw_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/mcqw_checker.sv
// Port-level checker for the motor command queue watchdog, bound to the top.
// Depends on mcqw_pkg and motor_command_queue_watchdog.
module mcqw_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input mcqw_pkg::t_out_item  o_out_item
);

    // A stalled result stays and holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // An accepted item occupies the block for the following cycles.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("input accepted while an item is in flight");

    // A new result only comes from an item that was in flight.
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid && i_out_stall) |-> $past(o_in_stall))
        else $error("result without an item in flight");

    // A watchdog stop rewrites both motors to zero and clears moving.
    a_timeout_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.timed_out |-> o_out_item.motor_write &&
            !o_out_item.moving && !o_out_item.command_taken &&
            (o_out_item.motor_left == 8'd0) && (o_out_item.motor_right == 8'd0))
        else $error("watchdog stop with motors still driven");

    // A dropped push changes nothing on the motors.
    a_drop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.push_dropped |-> !o_out_item.motor_write &&
            !o_out_item.timed_out && !o_out_item.command_taken)
        else $error("dropped push reported motor activity");

endmodule

bind motor_command_queue_watchdog mcqw_checker u_mcqw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
